### hdl/huffman_table_decoder_assert.svh
// ----------------------------------------------------------------------------
// Huffman table decoder assertion macros
// Shared forms for the concurrent checks in the decoder module.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_ASSERT_SVH

// check cons in the same cycle as ante
`define HTD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("huffman_table_decoder: assertion failed");

// check cons in the cycle after ante
`define HTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("huffman_table_decoder: assertion failed");

`endif

### hdl/htd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table decoder package
// Field widths, opcodes, defaults and shared types of the decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_CODE_BITS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 32;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    localparam logic [SYM_W-1:0] SYM_ASCII_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NUL        = 8'h00;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] sym;
    } t_match;

endpackage
`default_nettype wire

### hdl/huffman_table_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table decoder
// Decodes MSB-first compressed bytes against a loaded explicit code table.
//
//   channel  direction  handshake               payload
//   in       request    i_in_valid / o_in_stall  opcode, entry fields, byte
//   out      result     o_out_valid / i_out_stall symbol, last, done, error
//   cfg      write      i_cfg_wr_en              symbol_count
//
// Start and load requests are handled in the idle state without a stall.
// A decode request shifts in one bit at a time (shift state), then compares
// the table entries in order in the compare state up to the first match (a
// single compare with an empty table), passes each result through the emit
// state and ends in the closing state; the table read port and the single
// match unit make the scan go one entry at a time.
// Synchronous reset; the table has no clearing pass, only entries below the
// loaded count are scanned.
// One held result plus the output register absorb a stalled output side; the
// scan waits while both are full.
// ----------------------------------------------------------------------------
module huffman_table_decoder
    import htd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [SYM_W-1:0]  i_entry_symbol,
    input  wire logic [LEN_W-1:0]  i_entry_length,
    input  wire logic [CODE_W-1:0] i_entry_code,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [SYM_W-1:0]       o_out_symbol,
    output logic                   o_last_of_run,
    output logic                   o_message_done,
    output logic                   o_overflow_error
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW   = $clog2(MAX_CODE_BITS + 1);
    localparam int BW   = $clog2(BYTE_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_CMP   = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FINAL = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNTW-1:0]          r_count, n_count;
    logic [MAX_CODE_BITS-1:0] r_acc, n_acc;
    logic [LW-1:0]            r_len, n_len;
    logic [CFG_W-1:0]         r_remaining, n_remaining;
    logic [CFG_W-1:0]         r_symbol_count;
    logic [BYTE_W-1:0]        r_byte, n_byte;
    logic [BW-1:0]            r_bit, n_bit;
    logic [IW-1:0]            r_idx, n_idx;
    logic [SYM_W-1:0]         r_new_sym, n_new_sym;
    logic                     r_new_done, n_new_done;
    logic                     r_new_err, n_new_err;
    logic                     r_pend_vld, n_pend_vld;
    logic [SYM_W-1:0]         r_pend_sym, n_pend_sym;
    logic                     r_pend_done, n_pend_done;
    logic                     r_pend_err, n_pend_err;
    logic                     r_out_valid, n_out_valid;
    logic [SYM_W-1:0]         r_out_sym, n_out_sym;
    logic                     r_out_last, n_out_last;
    logic                     r_out_done, n_out_done;
    logic                     r_out_err, n_out_err;

    logic   in_acc;
    logic   can_load;
    logic   room;
    logic   scan_end;
    logic   hit;
    logic   tbl_wr_en;
    t_entry tbl_wr_data;
    t_entry tbl_rd_data;
    t_match match;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign can_load   = !r_out_valid || !i_out_stall;
    assign room       = (r_count < CNTW'(TABLE_ENTRIES));
    assign scan_end   = ((CNTW'(r_idx) + CNTW'(1)) >= r_count);
    assign hit        = match.hit && (r_count != '0);

    assign tbl_wr_en        = in_acc && (i_opcode == OP_LOAD) && room;
    assign tbl_wr_data.sym  = i_entry_symbol;
    assign tbl_wr_data.len  = i_entry_length;
    assign tbl_wr_data.code = i_entry_code;

    htd_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (tbl_wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (tbl_rd_data)
    );

    htd_match #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_match (
        .i_entry (tbl_rd_data),
        .i_acc   (r_acc),
        .i_len   (r_len),
        .o_match (match)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_acc       = r_acc;
        n_len       = r_len;
        n_remaining = r_remaining;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_new_sym   = r_new_sym;
        n_new_done  = r_new_done;
        n_new_err   = r_new_err;
        n_pend_vld  = r_pend_vld;
        n_pend_sym  = r_pend_sym;
        n_pend_done = r_pend_done;
        n_pend_err  = r_pend_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        n_out_err   = r_out_err;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        OP_START: begin
                            n_count     = '0;
                            n_acc       = '0;
                            n_len       = '0;
                            n_remaining = r_symbol_count;
                        end
                        OP_LOAD: begin
                            if (room) begin
                                n_count = r_count + CNTW'(1);
                            end
                        end
                        OP_DECODE: begin
                            if (r_remaining != '0) begin
                                n_byte  = i_data_byte;
                                n_bit   = BW'(BYTE_W - 1);
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                n_acc   = {r_acc[MAX_CODE_BITS-2:0], r_byte[r_bit]};
                n_len   = r_len + LW'(1);
                n_idx   = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_acc       = '0;
                    n_len       = '0;
                    n_remaining = r_remaining - CFG_W'(1);
                    n_new_sym   = match.sym;
                    n_new_done  = (r_remaining == CFG_W'(1));
                    n_new_err   = 1'b0;
                    n_state     = S_EMIT;
                end else if (!scan_end) begin
                    n_idx = r_idx + IW'(1);
                end else if (r_len == LW'(MAX_CODE_BITS)) begin
                    n_acc      = '0;
                    n_len      = '0;
                    n_new_sym  = SYM_NUL;
                    n_new_done = 1'b0;
                    n_new_err  = 1'b1;
                    n_state    = S_EMIT;
                end else if (r_bit == '0) begin
                    n_state = S_FINAL;
                end else begin
                    n_bit   = r_bit - BW'(1);
                    n_state = S_SHIFT;
                end
            end
            S_EMIT: begin
                if (!r_pend_vld || can_load) begin
                    if (r_pend_vld) begin
                        n_out_valid = 1'b1;
                        n_out_sym   = r_pend_sym;
                        n_out_last  = 1'b0;
                        n_out_done  = r_pend_done;
                        n_out_err   = r_pend_err;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_sym  = r_new_sym;
                    n_pend_done = r_new_done;
                    n_pend_err  = r_new_err;
                    if (r_new_done || (r_bit == '0)) begin
                        n_state = S_FINAL;
                    end else begin
                        n_bit   = r_bit - BW'(1);
                        n_state = S_SHIFT;
                    end
                end
            end
            S_FINAL: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_pend_sym;
                    n_out_last  = 1'b1;
                    n_out_done  = r_pend_done;
                    n_out_err   = r_pend_err;
                    n_pend_vld  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_acc          <= '0;
            r_len          <= '0;
            r_remaining    <= '0;
            r_symbol_count <= '0;
            r_pend_vld     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_len       <= n_len;
            r_remaining <= n_remaining;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_symbol_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_bit       <= n_bit;
        r_idx       <= n_idx;
        r_new_sym   <= n_new_sym;
        r_new_done  <= n_new_done;
        r_new_err   <= n_new_err;
        r_pend_sym  <= n_pend_sym;
        r_pend_done <= n_pend_done;
        r_pend_err  <= n_pend_err;
        r_out_sym   <= n_out_sym;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_symbol     = r_out_sym;
    assign o_last_of_run    = r_out_last;
    assign o_message_done   = r_out_done;
    assign o_overflow_error = r_out_err;

`include "huffman_table_decoder_assert.svh"

    `HTD_ASSERT_IMPL(a_idle_no_pending, (r_state == S_IDLE), !r_pend_vld)
    `HTD_ASSERT_IMPL(a_len_in_range, 1'b1, (r_len <= LW'(MAX_CODE_BITS)))
    `HTD_ASSERT_IMPL(a_count_in_range, 1'b1, (r_count <= CNTW'(TABLE_ENTRIES)))
    `HTD_ASSERT_IMPL(a_error_clean, r_out_valid && r_out_err, !r_out_done && r_out_sym == SYM_NUL)
    `HTD_ASSERT_IMPL(a_done_empties_budget, r_state == S_EMIT && r_new_done, r_remaining == '0)
    `HTD_ASSERT_NEXT(a_start_clears, in_acc && i_opcode == OP_START, r_len == '0)

endmodule
`default_nettype wire

### hdl/htd_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table decoder code table
// One write port for entry loads, one registered read port for the scan.
// ----------------------------------------------------------------------------
module htd_table
    import htd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_wr_addr,
    input  wire t_entry                           i_wr_data,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_rd_addr,
    output t_entry                                o_rd_data
);

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### hdl/htd_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table decoder entry match unit
// Compares one table entry with the gathered code and maps the symbol.
// ----------------------------------------------------------------------------
module htd_match
    import htd_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  wire t_entry                                 i_entry,
    input  wire logic [MAX_CODE_BITS-1:0]               i_acc,
    input  wire logic [$clog2(MAX_CODE_BITS+1)-1:0]     i_len,
    output t_match                                      o_match
);

    localparam int LW     = $clog2(MAX_CODE_BITS + 1);
    localparam int CMP_LW = (LW > LEN_W) ? LW : LEN_W;
    localparam int CMP_KW = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;

    logic len_eq;
    logic code_eq;

    assign len_eq  = (CMP_LW'(i_entry.len) == CMP_LW'(i_len));
    assign code_eq = (CMP_KW'(i_entry.code) == CMP_KW'(i_acc));

    assign o_match.hit = len_eq && code_eq;
    assign o_match.sym = (i_entry.sym == SYM_ASCII_ZERO) ? SYM_NUL : i_entry.sym;

endmodule
`default_nettype wire

### tb/huffman_table_decoder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman table decoder checker
// Watches the request, result and register ports of the decoder. Keeps its
// own code table, bit accumulator and symbol budget, works out the symbols
// that each accepted request yields, and compares every accepted result
// field by field with the oldest symbol still outstanding.
// ----------------------------------------------------------------------------
module huffman_table_decoder_chk
    import htd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [SYM_W-1:0]  i_entry_symbol,
    input  wire logic [LEN_W-1:0]  i_entry_length,
    input  wire logic [CODE_W-1:0] i_entry_code,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [SYM_W-1:0]  i_out_symbol,
    input  wire logic              i_last_of_run,
    input  wire logic              i_message_done,
    input  wire logic              i_overflow_error,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             done;
        logic             err;
    } t_decoded;

    t_decoded          queued_symbols[$];
    logic [SYM_W-1:0]  tbl_sym  [TABLE_ENTRIES_DEF];
    logic [LEN_W-1:0]  tbl_len  [TABLE_ENTRIES_DEF];
    logic [CODE_W-1:0] tbl_code [TABLE_ENTRIES_DEF];
    int                entry_cnt;
    logic [CODE_W-1:0] acc_bits;
    logic [LEN_W-1:0]  acc_len;
    logic [CFG_W-1:0]  count_reg;
    logic [CFG_W-1:0]  syms_left;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_result();
        t_decoded want;
        if (queued_symbols.size() == 0) begin
            report_mismatch("result with no symbol outstanding", 32'(i_out_symbol), 0);
        end else begin
            want = queued_symbols.pop_front();
            if (i_out_symbol !== want.sym)
                report_mismatch("out_symbol", 32'(i_out_symbol), 32'(want.sym));
            if (i_last_of_run !== want.last)
                report_mismatch("last_of_run", 32'(i_last_of_run), 32'(want.last));
            if (i_message_done !== want.done)
                report_mismatch("message_done", 32'(i_message_done), 32'(want.done));
            if (i_overflow_error !== want.err)
                report_mismatch("overflow_error", 32'(i_overflow_error), 32'(want.err));
        end
    endtask

    task automatic step_decoder();
        t_decoded         run[BYTE_W];
        t_decoded         r;
        int               n;
        int               k;
        int               b;
        int               hit;
        logic             halt;
        logic [SYM_W-1:0] s;
        n    = 0;
        halt = 1'b0;
        case (i_opcode)
            OP_START: begin
                entry_cnt = 0;
                acc_bits  = '0;
                acc_len   = '0;
                syms_left = count_reg;
            end
            OP_LOAD: begin
                if (entry_cnt < TABLE_ENTRIES_DEF) begin
                    tbl_sym[entry_cnt]  = i_entry_symbol;
                    tbl_len[entry_cnt]  = i_entry_length;
                    tbl_code[entry_cnt] = i_entry_code;
                    entry_cnt = entry_cnt + 1;
                end
            end
            OP_DECODE: begin
                if (syms_left != 0) begin
                    for (b = BYTE_W - 1; b >= 0; b--) begin
                        if (!halt) begin
                            acc_bits = {acc_bits[CODE_W-2:0], i_data_byte[b]};
                            acc_len  = acc_len + 1'b1;
                            hit = -1;
                            for (k = 0; k < entry_cnt; k++) begin
                                if (hit < 0 && tbl_len[k] == acc_len && tbl_code[k] == acc_bits)
                                    hit = k;
                            end
                            if (hit >= 0) begin
                                s = tbl_sym[hit];
                                if (s == SYM_ASCII_ZERO)
                                    s = SYM_NUL;
                                acc_bits  = '0;
                                acc_len   = '0;
                                syms_left = syms_left - 1'b1;
                                r.sym  = s;
                                r.last = 1'b0;
                                r.done = (syms_left == 0);
                                r.err  = 1'b0;
                                run[n] = r;
                                n = n + 1;
                                halt = (syms_left == 0);
                            end else if (acc_len >= LEN_W'(MAX_CODE_BITS_DEF)) begin
                                acc_bits = '0;
                                acc_len  = '0;
                                r.sym  = SYM_NUL;
                                r.last = 1'b0;
                                r.done = 1'b0;
                                r.err  = 1'b1;
                                run[n] = r;
                                n = n + 1;
                            end
                        end
                    end
                    for (k = 0; k < n; k++) begin
                        r = run[k];
                        r.last = (k == n - 1);
                        queued_symbols.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_cnt = 0;
            acc_bits  = '0;
            acc_len   = '0;
            syms_left = '0;
            count_reg = '0;
            queued_symbols.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                step_decoder();
            if (i_cfg_wr_en)
                count_reg = i_cfg_wr_data;
        end
        o_pending <= queued_symbols.size();
    end

endmodule

### tb/huffman_table_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman table decoder testbench
// Drives start, table load and data byte requests into the decoder: a short
// directed sequence over the corner cases, then phases of random prefix code
// tables with encoded symbol streams, noise and broken sequences. Both
// channels idle at random; a checker beside the decoder predicts and compares
// every result.
// ----------------------------------------------------------------------------
module huffman_table_decoder_tb;
    import htd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8 * (TABLE_ENTRIES_DEF + 1) + 2 * BYTE_W + 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int ITEM_TARGET    = 150;
    localparam int LIMIT_NS       = 10_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic [OP_W-1:0]   opcode = OP_START;
    logic [SYM_W-1:0]  entry_symbol = '0;
    logic [LEN_W-1:0]  entry_length = '0;
    logic [CODE_W-1:0] entry_code = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [SYM_W-1:0]  out_symbol;
    logic              last_of_run;
    logic              message_done;
    logic              overflow_error;
    int                fail_count;
    int                pending;
    logic              calm_tx = 1'b0;
    logic              calm_rx = 1'b0;
    int                hold_asks = 0;
    int                sent_items = 0;

    always #6 clk = ~clk;

    huffman_table_decoder u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_entry_symbol   (entry_symbol),
        .i_entry_length   (entry_length),
        .i_entry_code     (entry_code),
        .i_data_byte      (data_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_symbol     (out_symbol),
        .o_last_of_run    (last_of_run),
        .o_message_done   (message_done),
        .o_overflow_error (overflow_error)
    );

    huffman_table_decoder_chk u_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_entry_symbol   (entry_symbol),
        .i_entry_length   (entry_length),
        .i_entry_code     (entry_code),
        .i_data_byte      (data_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_symbol     (out_symbol),
        .i_last_of_run    (last_of_run),
        .i_message_done   (message_done),
        .i_overflow_error (overflow_error),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                                input logic [BYTE_W-1:0] data_in);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        entry_symbol <= sym;
        entry_length <= len;
        entry_code   <= code;
        data_byte    <= data_in;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sent_items = sent_items + 1;
    endtask

    task automatic send_start();
        send_request(OP_START, SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)),
                     CODE_W'($urandom_range(0, 65535)), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                             input logic [CODE_W-1:0] code);
        send_request(OP_LOAD, sym, len, code, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_decode(input logic [BYTE_W-1:0] data_in);
        send_request(OP_DECODE, SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)),
                     CODE_W'($urandom_range(0, 65535)), data_in);
    endtask

    task automatic drain_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stall runs, plus a long hold on request
    initial begin : rx_stall_gen
        int   run_left;
        int   hold_done;
        logic level;
        run_left  = 0;
        hold_done = 0;
        level     = 1'b0;
        forever begin
            @(posedge clk);
            if (run_left == 0) begin
                if (hold_asks != hold_done) begin
                    hold_done = hold_asks;
                    level     = 1'b1;
                    run_left  = RX_HOLD_CYCLES;
                end else if (level || calm_rx) begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 12);
                end else begin
                    level    = 1'b1;
                    run_left = 1 + pick_gap(1'b0);
                end
            end
            out_stall <= level;
            run_left = run_left - 1;
        end
    end

    initial begin : stimulus
        int                ph;
        int                n_target;
        int                maxl;
        int                drop;
        int                n_syms;
        int                sel;
        int                kind;
        int                i;
        int                b;
        int                r;
        int                pick;
        int                n_leaves;
        int                leaf_len [32];
        int                leaf_code[32];
        logic [SYM_W-1:0]  leaf_sym [32];
        logic              chain;
        logic [CFG_W-1:0]  budget;
        logic [BYTE_W-1:0] data_val;
        bit                stream_bits[$];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases: unused opcode, empty table overflow, 0x30 mapping,
        // first-loaded entry wins, odd entries, budget running out
        write_count({CFG_W{1'b1}});
        send_request(OP_UNUSED, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF);
        send_start();
        send_decode(8'hA5);
        send_decode(8'hFF);
        send_load(SYM_ASCII_ZERO, 5'd1, 16'h0000);
        send_load(8'h41, 5'd1, 16'h0000);
        send_load(8'hFF, 5'd2, 16'h0002);
        send_load(8'h00, 5'd0, 16'h0000);
        send_load(8'h77, 5'd31, 16'hFFFF);
        send_load(8'h12, 5'd2, 16'h0007);
        send_load(8'hAB, 5'd16, 16'hFFFF);
        send_decode(8'h00);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'h9B);
        drain_idle();
        write_count(32'd2);
        send_start();
        send_load(8'h55, 5'd1, 16'h0001);
        send_load(SYM_ASCII_ZERO, 5'd1, 16'h0000);
        send_decode(8'h4F);
        send_decode(8'h00);
        drain_idle();
        write_count('0);
        send_start();
        send_decode(8'hFF);
        drain_idle();

        ph = 0;
        while (sent_items < ITEM_TARGET) begin
            n_target = $urandom_range(2, 12);
            maxl     = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(3, 8);
            chain    = ($urandom_range(0, 6) == 0);
            if (chain) begin
                n_target = 17;
                maxl     = 16;
            end
            n_syms = $urandom_range(4, 24);
            r = $urandom_range(0, 99);
            if (r < 15)
                budget = {CFG_W{1'b1}};
            else if (r < 22)
                budget = 1;
            else if (r < 35)
                budget = n_syms / 2;
            else
                budget = n_syms;
            if (ph == 1) begin
                n_target = 4;
                maxl     = 2;
                chain    = 1'b0;
                n_syms   = 64;
                budget   = {CFG_W{1'b1}};
            end
            calm_tx = (ph == 1) || (ph == 3);
            calm_rx = (ph == 3);

            n_leaves     = 1;
            leaf_len[0]  = 0;
            leaf_code[0] = 0;
            while (n_leaves < n_target) begin
                pick = chain ? n_leaves - 1 : $urandom_range(0, n_leaves - 1);
                if (leaf_len[pick] >= maxl) begin
                    pick = -1;
                    for (i = 0; i < n_leaves; i++)
                        if (pick < 0 && leaf_len[i] < maxl)
                            pick = i;
                end
                if (pick < 0) begin
                    n_target = n_leaves;
                end else begin
                    leaf_len[n_leaves]  = leaf_len[pick] + 1;
                    leaf_code[n_leaves] = (leaf_code[pick] << 1) | 1;
                    leaf_len[pick]      = leaf_len[pick] + 1;
                    leaf_code[pick]     = leaf_code[pick] << 1;
                    n_leaves = n_leaves + 1;
                end
            end
            for (i = 0; i < n_leaves; i++)
                leaf_sym[i] = ($urandom_range(0, 3) == 0) ? SYM_ASCII_ZERO
                                                          : SYM_W'($urandom_range(0, 255));
            drop = ($urandom_range(0, 6) == 0 && ph != 1) ? $urandom_range(0, n_leaves - 1)
                                                          : -1;

            write_count(budget);
            send_start();
            for (i = 0; i < n_leaves; i++) begin
                if (i != drop) begin
                    send_load(leaf_sym[i], LEN_W'(leaf_len[i]), CODE_W'(leaf_code[i]));
                    if ($urandom_range(0, 6) == 0) begin
                        kind = $urandom_range(0, 3);
                        case (kind)
                            0: send_load(SYM_W'($urandom_range(0, 255)), 5'd0,
                                         CODE_W'($urandom_range(0, 65535)));
                            1: send_load(SYM_W'($urandom_range(0, 255)),
                                         LEN_W'($urandom_range(17, 31)),
                                         CODE_W'($urandom_range(0, 65535)));
                            2: begin
                                b = $urandom_range(1, 15);
                                send_load(SYM_W'($urandom_range(0, 255)), LEN_W'(b),
                                          CODE_W'($urandom_range(0, 65535) | (1 << b)));
                            end
                            default: send_load(SYM_W'($urandom_range(0, 255)),
                                               LEN_W'(leaf_len[i]), CODE_W'(leaf_code[i]));
                        endcase
                    end
                end
            end

            stream_bits.delete();
            for (i = 0; i < n_syms; i++) begin
                sel = $urandom_range(0, n_leaves - 1);
                if (sel == drop)
                    sel = (sel + 1) % n_leaves;
                for (b = leaf_len[sel] - 1; b >= 0; b--)
                    stream_bits.push_back(1'((leaf_code[sel] >> b) & 1));
            end

            if (ph == 1)
                hold_asks = hold_asks + 1;
            while (stream_bits.size() > 0) begin
                for (b = BYTE_W - 1; b >= 0; b--) begin
                    if (stream_bits.size() > 0)
                        data_val[b] = stream_bits.pop_front();
                    else
                        data_val[b] = 1'($urandom_range(0, 1));
                end
                r = $urandom_range(0, 99);
                if (ph != 1) begin
                    if (r < 4) begin
                        send_request(OP_UNUSED, SYM_W'($urandom_range(0, 255)),
                                     LEN_W'($urandom_range(0, 31)),
                                     CODE_W'($urandom_range(0, 65535)),
                                     BYTE_W'($urandom_range(0, 255)));
                    end else if (r < 9) begin
                        send_decode(BYTE_W'($urandom_range(0, 255)));
                    end else if (r < 11) begin
                        send_start();
                    end
                end
                send_decode(data_val);
            end
            calm_tx = 1'b0;
            calm_rx = 1'b0;
            drain_idle();
            ph = ph + 1;
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
